>>> hw/rtl/aof_pkg.sv
// ----------------------------------------------------------------------------
// aof_pkg
// Shared types and constants of the OBU framer: the beat formats of both
// channels, the parser phases and the per-byte event record between the
// parser and the result serializer.
// ----------------------------------------------------------------------------
package aof_pkg;

  // Width of every offset, size and length field.
  localparam int unsigned OFFSET_BITS = 24;
  localparam logic [OFFSET_BITS-1:0] LEN_MAX = {OFFSET_BITS{1'b1}};

  // Depth of the event queue between the parser and the serializer.
  localparam int unsigned QUEUE_DEPTH = 4;

  // OBU type codes that the framer reacts to.
  localparam logic [3:0] OBU_SEQ_HDR  = 4'd1;
  localparam logic [3:0] OBU_TD       = 4'd2;
  localparam logic [3:0] OBU_FHDR     = 4'd3;
  localparam logic [3:0] OBU_TILE_GRP = 4'd4;
  localparam logic [3:0] OBU_FRM      = 4'd6;

  // Bit positions in the frame content flags.
  localparam int unsigned FL_SEQ  = 0;
  localparam int unsigned FL_FHDR = 1;
  localparam int unsigned FL_DATA = 2;

  // Result kinds.
  localparam logic KIND_OBU   = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Parser phase within one OBU.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EXT,
    PH_LEB,
    PH_PAYLOAD
  } phase_t;

  // Input beat: one packet byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } obu_in_t;

  // Output beat: one OBU descriptor or one frame record.
  typedef struct packed {
    logic                   kind;
    logic [3:0]             obu_type;
    logic [OFFSET_BITS-1:0] obu_offset;
    logic [OFFSET_BITS-1:0] obu_len;
    logic [OFFSET_BITS-1:0] pay_offset;
    logic [OFFSET_BITS-1:0] pay_len;
    logic [OFFSET_BITS-1:0] frame_length;
    logic                   saw_sequence_header;
    logic                   saw_frame_header;
    logic                   saw_frame_data;
    logic                   ends_packet;
    logic                   last;
  } obu_out_t;

  // Everything that one input byte causes: an optional frame close, an
  // optional OBU descriptor and an optional packet-end frame record.
  typedef struct packed {
    logic                   has_close;
    logic                   has_desc;
    logic                   has_end;
    logic [OFFSET_BITS-1:0] close_len;
    logic [2:0]             close_flags;
    logic [3:0]             obu_type;
    logic [OFFSET_BITS-1:0] obu_offset;
    logic [OFFSET_BITS-1:0] obu_len;
    logic [OFFSET_BITS-1:0] pay_offset;
    logic [OFFSET_BITS-1:0] pay_len;
    logic [OFFSET_BITS-1:0] end_len;
    logic [2:0]             end_flags;
  } obu_event_t;

endpackage

>>> hw/rtl/aof_front.sv
// ----------------------------------------------------------------------------
// aof_front
// Byte parser. Walks the OBU header, extension byte, LEB128 size and payload,
// keeps the frame byte count and content flags, and turns each byte into at
// most one event record for the serializer.
// ----------------------------------------------------------------------------
module aof_front
  import aof_pkg::*;
#(
  parameter int unsigned LEB_BYTES_MAX = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  obu_in_t    in_data,
  output logic       ev_push,
  output obu_event_t ev_data,
  input  logic       ev_full
);

  localparam int unsigned LEBW = 7 * LEB_BYTES_MAX;
  localparam int unsigned LCW  = $clog2(LEB_BYTES_MAX + 1);
  localparam int unsigned EXTW = (LEBW > OFFSET_BITS) ? LEBW : OFFSET_BITS + 1;
  localparam int unsigned OB   = OFFSET_BITS;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      type_r, type_nxt;
  logic            size_r, size_nxt;
  logic [LEBW-1:0] leb_r, leb_nxt;
  logic [LCW-1:0]  leb_cnt_r, leb_cnt_nxt;
  logic [3:0]      hdr_r, hdr_nxt;
  logic [OB-1:0]   left_r, left_nxt;
  logic [OB-1:0]   cnt_r, cnt_nxt;
  logic [OB-1:0]   fb_r, fb_nxt;
  logic [2:0]      flags_r, flags_nxt;

  logic            accept;
  logic [7:0]      b;
  logic            pend;
  logic            done;
  logic [3:0]      hb;
  logic [3:0]      type_cur;
  logic [OB-1:0]   psize;
  logic [LEBW-1:0] leb_new;
  logic [EXTW-1:0] leb_ext;
  logic [OB-1:0]   leb_sat;
  logic            leb_fin;
  logic [OB-1:0]   left_dec;
  logic [OB-1:0]   cnt_inc;
  logic [OB:0]     osize;
  logic            is_close;
  logic [OB-1:0]   fb_eff;
  logic [OB+1:0]   fb_sum;
  logic [OB-1:0]   fb_after;
  logic [2:0]      flags_after;
  logic [OB-1:0]   fb_cur;
  logic [2:0]      flags_cur;
  logic            has_end;

  assign in_ready = !ev_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign pend     = in_data.packet_end;

  // Merge the current LEB128 byte into its 7-bit group.
  always_comb begin
    leb_new = leb_r;
    for (int k = 0; k < LEB_BYTES_MAX; k++) begin
      if (leb_cnt_r == LCW'(k)) begin
        leb_new[7*k +: 7] = leb_r[7*k +: 7] | b[6:0];
      end
    end
    leb_ext = EXTW'(leb_new);
    leb_sat = (|leb_ext[EXTW-1:OB]) ? LEN_MAX : leb_ext[OB-1:0];
    leb_fin = !b[7] || (leb_cnt_r == LCW'(LEB_BYTES_MAX - 1));
  end

  // Saturating payload counters.
  assign left_dec = (left_r != '0) ? left_r - OB'(1) : left_r;
  assign cnt_inc  = (cnt_r == LEN_MAX) ? cnt_r : cnt_r + OB'(1);

  // Phase register and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      type_r    <= '0;
      size_r    <= 1'b0;
      leb_r     <= '0;
      leb_cnt_r <= '0;
      hdr_r     <= '0;
      left_r    <= '0;
      cnt_r     <= '0;
      fb_r      <= '0;
      flags_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      type_r    <= type_nxt;
      size_r    <= size_nxt;
      leb_r     <= leb_nxt;
      leb_cnt_r <= leb_cnt_nxt;
      hdr_r     <= hdr_nxt;
      left_r    <= left_nxt;
      cnt_r     <= cnt_nxt;
      fb_r      <= fb_nxt;
      flags_r   <= flags_nxt;
    end
  end

  // Next state and the event record for the accepted byte.
  always_comb begin
    phase_nxt   = phase_r;
    type_nxt    = type_r;
    size_nxt    = size_r;
    leb_nxt     = leb_r;
    leb_cnt_nxt = leb_cnt_r;
    hdr_nxt     = hdr_r;
    left_nxt    = left_r;
    cnt_nxt     = cnt_r;
    fb_nxt      = fb_r;
    flags_nxt   = flags_r;
    done        = 1'b0;
    hb          = hdr_r;
    psize       = '0;

    case (phase_r)
      PH_HEADER: begin
        type_nxt    = b[6:3];
        size_nxt    = b[1];
        hb          = 4'd1;
        hdr_nxt     = 4'd1;
        leb_nxt     = '0;
        leb_cnt_nxt = '0;
        left_nxt    = '0;
        cnt_nxt     = '0;
        if (b[2]) begin
          phase_nxt = PH_EXT;
        end else begin
          phase_nxt = b[1] ? PH_LEB : PH_PAYLOAD;
          done      = pend;
        end
      end
      PH_EXT: begin
        hb        = hdr_r + 4'd1;
        hdr_nxt   = hb;
        phase_nxt = size_r ? PH_LEB : PH_PAYLOAD;
        done      = pend;
      end
      PH_LEB: begin
        hb          = hdr_r + 4'd1;
        hdr_nxt     = hb;
        leb_nxt     = leb_new;
        leb_cnt_nxt = leb_cnt_r + LCW'(1);
        if (leb_fin) begin
          left_nxt = leb_sat;
          cnt_nxt  = leb_sat;
          if (leb_new == '0) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        // An unfinished size that reads zero at the packet end still completes the OBU.
        if (pend && leb_new == '0) begin
          done = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (size_r) begin
          left_nxt = left_dec;
          done     = (left_dec == '0);
          psize    = cnt_r;
        end else begin
          cnt_nxt = cnt_inc;
          done    = pend;
          psize   = cnt_inc;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    type_cur = type_nxt;

    // Completed OBU: optional frame close, then the descriptor.
    is_close    = (type_cur inside {OBU_TD, OBU_FHDR, OBU_FRM}) &&
                  (flags_r[FL_FHDR] || flags_r[FL_DATA]);
    osize       = (OB + 1)'(hb) + (OB + 1)'(psize);
    fb_eff      = is_close ? '0 : fb_r;
    fb_sum      = (OB + 2)'(fb_eff) + (OB + 2)'(osize);
    fb_after    = (|fb_sum[OB+1:OB]) ? LEN_MAX : fb_sum[OB-1:0];
    flags_after = is_close ? 3'b000 : flags_r;
    if (type_cur == OBU_SEQ_HDR) begin
      flags_after[FL_SEQ] = 1'b1;
    end
    if (type_cur == OBU_FHDR) begin
      flags_after[FL_FHDR] = 1'b1;
    end
    if (type_cur == OBU_FRM || type_cur == OBU_TILE_GRP) begin
      flags_after[FL_DATA] = 1'b1;
    end

    if (done) begin
      phase_nxt   = PH_HEADER;
      hdr_nxt     = '0;
      leb_nxt     = '0;
      leb_cnt_nxt = '0;
      left_nxt    = '0;
      cnt_nxt     = '0;
      fb_nxt      = fb_after;
      flags_nxt   = flags_after;
    end

    fb_cur    = done ? fb_after : fb_r;
    flags_cur = done ? flags_after : flags_r;
    has_end   = pend && (fb_cur != '0);

    // Packet end clears everything.
    if (pend) begin
      phase_nxt   = PH_HEADER;
      type_nxt    = '0;
      size_nxt    = 1'b0;
      leb_nxt     = '0;
      leb_cnt_nxt = '0;
      hdr_nxt     = '0;
      left_nxt    = '0;
      cnt_nxt     = '0;
      fb_nxt      = '0;
      flags_nxt   = '0;
    end

    // A stalled or idle cycle keeps the state.
    if (!accept) begin
      phase_nxt   = phase_r;
      type_nxt    = type_r;
      size_nxt    = size_r;
      leb_nxt     = leb_r;
      leb_cnt_nxt = leb_cnt_r;
      hdr_nxt     = hdr_r;
      left_nxt    = left_r;
      cnt_nxt     = cnt_r;
      fb_nxt      = fb_r;
      flags_nxt   = flags_r;
    end

    ev_data.has_close   = done && is_close;
    ev_data.has_desc    = done;
    ev_data.has_end     = has_end;
    ev_data.close_len   = fb_r;
    ev_data.close_flags = flags_r;
    ev_data.obu_type    = type_cur;
    ev_data.obu_offset  = fb_eff;
    ev_data.obu_len     = osize[OB-1:0];
    ev_data.pay_offset  = fb_eff + OB'(hb);
    ev_data.pay_len     = psize;
    ev_data.end_len     = fb_cur;
    ev_data.end_flags   = flags_cur;
    ev_push             = accept && (done || has_end);
  end

endmodule

>>> hw/rtl/aof_queue.sv
// ----------------------------------------------------------------------------
// aof_queue
// Small event queue between the parser and the serializer, so that a byte
// that causes several results does not hold up the byte stream.
// ----------------------------------------------------------------------------
module aof_queue
  import aof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  obu_event_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output obu_event_t head_data
);

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  obu_event_t       mem_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full       = (count_r == (QAW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QAW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hw/rtl/aof_back.sv
// ----------------------------------------------------------------------------
// aof_back
// Result serializer. Expands the event at the head of the queue into one to
// three result beats, in the order frame close, descriptor, packet end, and
// holds each beat in the output register until it is taken.
// ----------------------------------------------------------------------------
module aof_back
  import aof_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ev_valid,
  input  obu_event_t ev_data,
  output logic       ev_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output obu_out_t   out_data
);

  logic       out_valid_r, out_valid_nxt;
  obu_out_t   out_data_r, out_data_nxt;
  logic [2:0] sent_r, sent_nxt;
  logic [2:0] rem;
  logic [2:0] pick;
  logic       load;
  logic       emit;
  logic       last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Choose the next record of the head event and build its beat.
  always_comb begin
    rem  = {ev_data.has_end, ev_data.has_desc, ev_data.has_close} & ~sent_r;
    load = !out_valid_r || out_ready;
    emit = ev_valid && load;
    if (rem[0]) begin
      pick = 3'b001;
    end else if (rem[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
    last   = ((rem & ~pick) == 3'b000);
    ev_pop = emit && last;

    out_data_nxt = '0;
    out_data_nxt.last = last;
    if (pick[1]) begin
      out_data_nxt.kind       = KIND_OBU;
      out_data_nxt.obu_type   = ev_data.obu_type;
      out_data_nxt.obu_offset = ev_data.obu_offset;
      out_data_nxt.obu_len    = ev_data.obu_len;
      out_data_nxt.pay_offset = ev_data.pay_offset;
      out_data_nxt.pay_len    = ev_data.pay_len;
    end else if (pick[0]) begin
      out_data_nxt.kind                = KIND_FRAME;
      out_data_nxt.frame_length        = ev_data.close_len;
      out_data_nxt.saw_sequence_header = ev_data.close_flags[FL_SEQ];
      out_data_nxt.saw_frame_header    = ev_data.close_flags[FL_FHDR];
      out_data_nxt.saw_frame_data      = ev_data.close_flags[FL_DATA];
    end else begin
      out_data_nxt.kind                = KIND_FRAME;
      out_data_nxt.frame_length        = ev_data.end_len;
      out_data_nxt.saw_sequence_header = ev_data.end_flags[FL_SEQ];
      out_data_nxt.saw_frame_header    = ev_data.end_flags[FL_FHDR];
      out_data_nxt.saw_frame_data      = ev_data.end_flags[FL_DATA];
      out_data_nxt.ends_packet         = 1'b1;
    end

    if (ev_pop) begin
      sent_nxt = 3'b000;
    end else if (emit) begin
      sent_nxt = sent_r | pick;
    end else begin
      sent_nxt = sent_r;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= 3'b000;
    end else begin
      out_valid_r <= out_valid_nxt;
      sent_r      <= sent_nxt;
    end
  end

  // Output beat register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> hw/rtl/av1_obu_framer.sv
// ----------------------------------------------------------------------------
// av1_obu_framer
// Streaming OBU framer: parses OBU headers and LEB128 sizes from a packet
// byte stream and reports OBU descriptors and closed frame records.
//
//   Channel  Direction  Payload    Beat
//   in_      input      obu_in_t   one packet byte, packet_end on the last
//   out_     output     obu_out_t  one OBU descriptor or one frame record
//
// The parser takes one byte per cycle while the event queue has room. The
// serializer sends one result beat per cycle while the output is taken, so
// a byte that causes two or three results holds the queue head until its
// last beat is sent. Reset (rst_n low, synchronous) empties the queue and
// the output register and puts the parser back to the start of a packet.
// Output stalls back up through the queue to in_ready only once the queue
// is full.
// ----------------------------------------------------------------------------
module av1_obu_framer
  import aof_pkg::*;
#(
  parameter int unsigned LEB_BYTES_MAX = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  obu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output obu_out_t out_data
);

  logic       ev_push;
  obu_event_t ev_push_data;
  logic       ev_full;
  logic       ev_pop;
  logic       ev_valid;
  obu_event_t ev_head;

  // Byte parser.
  aof_front #(
    .LEB_BYTES_MAX(LEB_BYTES_MAX)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ev_push  (ev_push),
    .ev_data  (ev_push_data),
    .ev_full  (ev_full)
  );

  // Event queue.
  aof_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_data  (ev_push_data),
    .full       (ev_full),
    .pop        (ev_pop),
    .head_valid (ev_valid),
    .head_data  (ev_head)
  );

  // Result serializer.
  aof_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev_valid  (ev_valid),
    .ev_data   (ev_head),
    .ev_pop    (ev_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> tb/av1_obu_framer_tb.sv
// ----------------------------------------------------------------------------
// av1_obu_framer_tb
// Self-checking testbench of the OBU framer. Packet bytes go in over the in_
// channel with random gaps, and result beats are taken with random stalls.
// A behavioral copy of the parser works out the descriptors and frame
// records that each accepted byte must cause, and every result beat is
// compared field by field against the oldest one still waiting. Directed
// packets cover headers, extensions, size fields and frame closes. Random
// packets of well-formed OBUs, with some truncated packets and noise, follow.
// ----------------------------------------------------------------------------
module av1_obu_framer_tb
  import aof_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEB_MAX = 8;
  localparam logic [63:0] LEN_CAP = 64'(LEN_MAX);

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  obu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  obu_out_t out_data;

  // Idling on both channels is switched by the running test.
  bit idle_on = 1'b1;
  int mismatch_count = 0;

  // Results still owed by the framer, oldest first.
  obu_out_t owed_results[$];
  logic [7:0] pkt_bytes[$];

  // Parser state of the behavioral copy.
  phase_t      ps_phase;
  logic [3:0]  ps_type;
  logic        ps_sized;
  logic [63:0] ps_leb;
  logic [3:0]  ps_leb_cnt;
  logic [3:0]  ps_hdr_len;
  logic [63:0] ps_left;
  logic [63:0] ps_frame_len;
  logic [2:0]  ps_flags;

  av1_obu_framer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Lengths stop at the largest value the offset fields can hold.
  function automatic logic [63:0] clip_len(logic [63:0] v);
    return (v > LEN_CAP) ? LEN_CAP : v;
  endfunction

  function automatic void clear_parser();
    ps_phase     = PH_HEADER;
    ps_type      = '0;
    ps_sized     = 1'b0;
    ps_leb       = '0;
    ps_leb_cnt   = '0;
    ps_hdr_len   = '0;
    ps_left      = '0;
    ps_frame_len = '0;
    ps_flags     = '0;
  endfunction

  function automatic obu_out_t frame_record(logic [63:0] len, logic [2:0] flags,
                                            logic ends);
    obu_out_t r;
    r = '0;
    r.kind                = KIND_FRAME;
    r.frame_length        = len[OFFSET_BITS-1:0];
    r.saw_sequence_header = flags[FL_SEQ];
    r.saw_frame_header    = flags[FL_FHDR];
    r.saw_frame_data      = flags[FL_DATA];
    r.ends_packet         = ends;
    return r;
  endfunction

  // Advance the parser copy by one accepted byte and queue what it causes.
  function automatic void predict_byte(logic [7:0] b, logic pend);
    logic        done;
    logic        fin;
    logic [3:0]  cnt;
    logic [63:0] psize;
    logic [63:0] osize;
    logic [63:0] poff;
    obu_out_t    r;
    int          first;
    done  = 1'b0;
    first = owed_results.size();
    case (ps_phase)
      PH_HEADER: begin
        ps_type    = b[6:3];
        ps_sized   = b[1];
        ps_hdr_len = 4'd1;
        ps_leb     = '0;
        ps_leb_cnt = '0;
        ps_left    = '0;
        if (b[2]) begin
          ps_phase = PH_EXT;
        end else begin
          ps_phase = ps_sized ? PH_LEB : PH_PAYLOAD;
          if (pend) done = 1'b1;
        end
      end
      PH_EXT: begin
        ps_hdr_len = ps_hdr_len + 4'd1;
        ps_phase   = ps_sized ? PH_LEB : PH_PAYLOAD;
        if (pend) done = 1'b1;
      end
      PH_LEB: begin
        cnt = ps_leb_cnt;
        if (cnt >= LEB_MAX) cnt = 4'(LEB_MAX - 1);
        ps_leb     = ps_leb | (64'(b[6:0]) << (7 * cnt));
        cnt        = cnt + 4'd1;
        ps_leb_cnt = cnt;
        ps_hdr_len = ps_hdr_len + 4'd1;
        // The size field also stops at its longest legal length.
        fin = !b[7] || (cnt >= LEB_MAX);
        if (fin) begin
          ps_left = clip_len(ps_leb);
          if (ps_leb == 0) done = 1'b1;
          else ps_phase = PH_PAYLOAD;
        end
        if (pend && !done && ps_leb == 0) done = 1'b1;
      end
      default: begin
        if (ps_sized) begin
          if (ps_left > 0) ps_left = ps_left - 1;
          if (ps_left == 0) done = 1'b1;
        end else begin
          // Without a size field the payload count lives in ps_leb.
          ps_leb = clip_len(ps_leb + 1);
          if (pend) done = 1'b1;
        end
      end
    endcase

    if (done) begin
      psize = clip_len(ps_leb);
      osize = 64'(ps_hdr_len) + psize;
      // A frame start closes a frame that already holds header or data.
      if ((ps_type == OBU_TD || ps_type == OBU_FHDR || ps_type == OBU_FRM) &&
          (ps_flags[FL_FHDR] || ps_flags[FL_DATA])) begin
        owed_results.insert(owed_results.size(),
                            frame_record(ps_frame_len, ps_flags, 1'b0));
        ps_frame_len = '0;
        ps_flags     = '0;
      end
      poff = ps_frame_len + 64'(ps_hdr_len);
      r = '0;
      r.kind       = KIND_OBU;
      r.obu_type   = ps_type;
      r.obu_offset = ps_frame_len[OFFSET_BITS-1:0];
      r.obu_len    = osize[OFFSET_BITS-1:0];
      r.pay_offset = poff[OFFSET_BITS-1:0];
      r.pay_len    = psize[OFFSET_BITS-1:0];
      owed_results.insert(owed_results.size(), r);
      ps_frame_len = clip_len(ps_frame_len + osize);
      if (ps_type == OBU_SEQ_HDR) ps_flags[FL_SEQ] = 1'b1;
      if (ps_type == OBU_FHDR) ps_flags[FL_FHDR] = 1'b1;
      if (ps_type == OBU_FRM || ps_type == OBU_TILE_GRP) ps_flags[FL_DATA] = 1'b1;
      ps_phase   = PH_HEADER;
      ps_hdr_len = '0;
      ps_leb     = '0;
      ps_leb_cnt = '0;
      ps_left    = '0;
    end

    if (pend) begin
      if (ps_frame_len != 0) begin
        owed_results.insert(owed_results.size(),
                            frame_record(ps_frame_len, ps_flags, 1'b1));
      end
      clear_parser();
    end

    if (owed_results.size() > first) begin
      owed_results[owed_results.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endtask

  // Send one byte beat. Called at a falling edge, returns at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic pend);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, packet_end: pend};
    do @(posedge clk); while (!in_ready);
    predict_byte(b, pend);
    @(negedge clk);
  endtask

  // Result side: random stalls, and each beat taken is checked.
  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
  end

  always @(posedge clk) begin : result_check
    obu_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        flag_error($sformatf("result beat with none owed: 0x%0h", out_data));
      end else begin
        want = owed_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("obu_type", 32'(want.obu_type), 32'(out_data.obu_type));
        check_field("obu_offset", 32'(want.obu_offset), 32'(out_data.obu_offset));
        check_field("obu_len", 32'(want.obu_len), 32'(out_data.obu_len));
        check_field("pay_offset", 32'(want.pay_offset), 32'(out_data.pay_offset));
        check_field("pay_len", 32'(want.pay_len), 32'(out_data.pay_len));
        check_field("frame_length", 32'(want.frame_length), 32'(out_data.frame_length));
        check_field("saw_sequence_header", 32'(want.saw_sequence_header),
                    32'(out_data.saw_sequence_header));
        check_field("saw_frame_header", 32'(want.saw_frame_header),
                    32'(out_data.saw_frame_header));
        check_field("saw_frame_data", 32'(want.saw_frame_data),
                    32'(out_data.saw_frame_data));
        check_field("ends_packet", 32'(want.ends_packet), 32'(out_data.ends_packet));
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Frame OBU with an extension byte and a size field, last in the packet.
  task automatic test_extension_frame();
    send_byte(8'h36, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b1);
  endtask

  // Frame header then frame: one byte closes the frame, describes the OBU
  // and ends the packet.
  task automatic test_frame_close();
    send_byte(8'h1A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h32, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Payload without a size field runs to the packet end, even an empty one.
  task automatic test_unsized_payload();
    send_byte(8'h08, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
    send_byte(8'h20, 1'b1);
  endtask

  // Size field absent, unfinished at zero, and unfinished at nonzero.
  task automatic test_short_size_field();
    send_byte(8'h0A, 1'b1);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h81, 1'b1);
  endtask

  // Packets that end before the extension byte or inside the payload.
  task automatic test_cut_short();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h0A, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  // Eight size bytes all with the continuation bit: the field stops there.
  task automatic test_long_size_field();
    send_byte(8'h0A, 1'b0);
    send_byte(8'h81, 1'b0);
    repeat (LEB_MAX - 1) send_byte(8'h80, 1'b0);
    send_byte(8'h5A, 1'b1);
  endtask

  // Random packets of well-formed OBUs, with truncated packets and noise.
  task automatic test_random_packets();
    int          random_bytes;
    int          n_obu;
    int          plen;
    int          nb;
    int          pad;
    int          cut;
    bit          has_ext;
    bit          sized;
    bit          big;
    logic [3:0]  typ;
    logic [63:0] leb_v;
    random_bytes = 0;
    while (random_bytes < 70) begin
      // A long stretch in the middle runs without any idling.
      idle_on = (random_bytes < 20) || (random_bytes >= 50);
      pkt_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
      end else begin
        n_obu = $urandom_range(1, 4);
        big   = 1'b0;
        for (int k = 0; k < n_obu && !big; k++) begin
          case ($urandom_range(0, 7))
            0:       typ = OBU_SEQ_HDR;
            1:       typ = OBU_TD;
            2:       typ = OBU_FHDR;
            3:       typ = OBU_TILE_GRP;
            4, 5:    typ = OBU_FRM;
            default: typ = 4'($urandom);
          endcase
          has_ext = ($urandom_range(0, 3) == 0);
          sized   = (k != n_obu - 1) || ($urandom_range(0, 3) != 0);
          big     = sized && ($urandom_range(0, 19) == 0);
          case ($urandom_range(0, 29))
            0:       plen = $urandom_range(100, 200);
            1, 2:    plen = $urandom_range(7, 40);
            default: plen = $urandom_range(0, 6);
          endcase
          pkt_bytes.insert(pkt_bytes.size(),
                           {1'($urandom), typ, has_ext, sized, 1'($urandom)});
          if (has_ext) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
          if (sized) begin
            // A huge declared size: the packet is cut inside its payload.
            leb_v = big ? ({$urandom, $urandom} & 64'h0001_FFFF_FFFF_FFFF) : 64'(plen);
            nb    = 0;
            do begin
              pkt_bytes.insert(pkt_bytes.size(), {(leb_v >> 7) != 0, leb_v[6:0]});
              leb_v = leb_v >> 7;
              nb++;
            end while (leb_v != 0);
            // Over-long but legal encodings pad with continuation bytes.
            pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, LEB_MAX - nb) : 0;
            if (pad > 0) begin
              pkt_bytes[pkt_bytes.size() - 1] = pkt_bytes[pkt_bytes.size() - 1] | 8'h80;
              for (int j = 1; j < pad; j++) pkt_bytes.insert(pkt_bytes.size(), 8'h80);
              pkt_bytes.insert(pkt_bytes.size(),
                               (nb + pad == LEB_MAX && $urandom_range(0, 1) == 1) ?
                               8'h80 : 8'h00);
            end
          end
          if (big) plen = $urandom_range(0, 3);
          repeat (plen) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
        end
        if (!big && $urandom_range(0, 9) < 2) begin
          cut = $urandom_range(1, pkt_bytes.size());
          while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
      end
      foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
      random_bytes += pkt_bytes.size();
    end
    idle_on = 1'b1;
  endtask

  initial begin : main
    int drain_cycles;
    clear_parser();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_extension_frame();
    test_frame_close();
    test_unsized_payload();
    test_short_size_field();
    test_cut_short();
    test_long_size_field();
    test_random_packets();
    in_valid <= 1'b0;

    // Let every owed result arrive, then watch a while for stray beats.
    drain_cycles = 0;
    while (owed_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (owed_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", owed_results.size()));
    if (mismatch_count == 0) begin
      $display("av1_obu_framer_tb OK");
    end else begin
      $display("av1_obu_framer_tb NOT OK");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #2_000_000;
    $display("av1_obu_framer_tb NOT OK");
    $finish;
  end

endmodule
